// ----- rtl/sbi_pkg.sv -----
// sbi_pkg: shared types, widths and codes for the stack bytecode interpreter.
// No dependencies; used by every module of the block.

package sbi_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int DATA_W      = 32;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = 8;
   localparam int STATUS_W    = 2;
   localparam int OP_W        = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   // stream payload layout
   localparam int REQ_FIELDS_W   = OP_W + DATA_W;
   localparam int REQ_TDATA_W    = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_LIT_LSB    = OP_W;
   localparam int RSP_FIELDS_W   = DATA_W + DEPTH_W + STATUS_W;
   localparam int RSP_TDATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DEPTH_LSB  = DATA_W;
   localparam int RSP_STATUS_LSB = DATA_W + DEPTH_W;

   // reset values
   localparam logic [DATA_W-1:0] ALLY_HEALTH_RST   = DATA_W'(45);
   localparam logic [DATA_W-1:0] ENEMY_HEALTH_RST  = DATA_W'(32);
   localparam logic [DATA_W-1:0] ALLY_AGILITY_RST  = DATA_W'(7);
   localparam logic [DATA_W-1:0] ALLY_WISDOM_RST   = DATA_W'(11);
   localparam logic [DATA_W-1:0] ENEMY_AGILITY_RST = DATA_W'(4);
   localparam logic [DATA_W-1:0] ENEMY_WISDOM_RST  = DATA_W'(7);

   typedef enum logic [OP_W-1:0] {
      OP_NONE        = 3'd0,
      OP_LITERAL     = 3'd1,
      OP_ADD         = 3'd2,
      OP_DIVIDE      = 3'd3,
      OP_SET_HEALTH  = 3'd4,
      OP_GET_HEALTH  = 3'd5,
      OP_GET_AGILITY = 3'd6,
      OP_GET_WISDOM  = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2,
      STAT_DIVZ  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALLY_AGILITY  = 2'd0,
      CSR_ALLY_WISDOM   = 2'd1,
      CSR_ENEMY_AGILITY = 2'd2,
      CSR_ENEMY_WISDOM  = 2'd3
   } csr_index_type;

   localparam logic [DATA_W-1:0] UNIT_ALLY  = DATA_W'(0);
   localparam logic [DATA_W-1:0] UNIT_ENEMY = DATA_W'(1);

endpackage

// ----- rtl/stack_bytecode_interpreter.sv -----
// stack_bytecode_interpreter: top level, instruction sequencer around the stack RAM.
// Depends on sbi_pkg, sbi_stack_ram and sbi_divider.

// Usage
//   req_* : one pre-decoded instruction per transaction (op and literal value).
//   rsp_* : exactly one result per instruction, in order: top of stack (0 when
//           empty), depth and status (ok, underflow, overflow, divide by zero).
//   csr_* : unit stat registers; write only with no instruction in flight (not enforced).
// Timing
//   One instruction at a time. req_tready is high while the sequencer is idle.
//   Literal, add, get and no-op run through accept (operand read issued to
//   the stack RAM) and execute (RAM write-back plus result load).
//   Set health adds a refill step when entries remain, since the new top must
//   be read back from the RAM. Divide adds a wait while the divider runs, then
//   a commit step that writes the quotient back. The result is loaded in the
//   last step.
// Reset
//   Synchronous, active high: empty stack, health 45/32, stats 7/11/4/7, no
//   result pending. The stack RAM itself is not cleared; entries above the
//   stack pointer never reach a result.
// Backpressure
//   A finished result sits in the output register while the next instruction
//   is accepted; execution holds (no state change) until that register frees.

module stack_bytecode_interpreter (
   input  logic                                clock,
   input  logic                                reset,
   // instruction stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sbi_pkg::REQ_TDATA_W-1:0]     req_tdata,  // op[2:0], literal_value[34:3]
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sbi_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // top_value[31:0], depth[39:32],
                                                           // status[41:40]
   // register writes
   input  logic                                csr_wr_en,
   input  logic [sbi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbi_pkg::DATA_W-1:0]          csr_wr_data
);

   localparam int W  = sbi_pkg::DATA_W;
   localparam int SW = sbi_pkg::SP_W;
   localparam int AW = sbi_pkg::ADDR_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DIVIDE,
      S_REFILL
   } state_type;

   state_type               state_ff, state_in;
   logic [SW-1:0]           sp_ff, sp_in;
   logic [W-1:0]            top_ff, top_in;       // copy of stack[sp-1]
   sbi_pkg::op_type         op_ff, op_in;
   logic [W-1:0]            lit_ff, lit_in;
   logic [W-1:0]            ally_health_ff, ally_health_in;
   logic [W-1:0]            enemy_health_ff, enemy_health_in;
   logic [W-1:0]            ally_agility_ff, ally_agility_in;
   logic [W-1:0]            ally_wisdom_ff, ally_wisdom_in;
   logic [W-1:0]            enemy_agility_ff, enemy_agility_in;
   logic [W-1:0]            enemy_wisdom_ff, enemy_wisdom_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]            rsp_top_ff, rsp_top_in;
   logic [sbi_pkg::DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;
   sbi_pkg::status_type     rsp_status_ff, rsp_status_in;

   // result load request
   logic                    resp_fire;
   logic [SW-1:0]           resp_sp;
   logic [W-1:0]            resp_top;
   sbi_pkg::status_type     resp_status;

   logic                    slot_free;
   logic [SW-1:0]           sp_m1, sp_m2, sp_m3;
   logic [W-1:0]            opnd_a, opnd_b, sum, stat;

   logic                    ram_wr_en, ram_rd_en;
   logic [AW-1:0]           ram_wr_addr, ram_rd_addr;
   logic [W-1:0]            ram_wr_data, ram_rd_data;

   logic                    div_start, div_busy;
   logic [W-1:0]            div_quotient;

   sbi_stack_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sbi_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (opnd_a),
      .divisor  (opnd_b),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign sp_m1      = sp_ff - SW'(1);
   assign sp_m2      = sp_ff - SW'(2);
   assign sp_m3      = sp_ff - SW'(3);
   assign opnd_a     = ram_rd_data;   // stack[sp-2], read during acceptance
   assign opnd_b     = top_ff;        // stack[sp-1]
   assign sum        = opnd_a + opnd_b;

   // stat lookup for the unit index on top of the stack
   always_comb begin
      stat = '0;
      if (top_ff == sbi_pkg::UNIT_ALLY) begin
         unique case (op_ff)
            sbi_pkg::OP_GET_HEALTH:  stat = ally_health_ff;
            sbi_pkg::OP_GET_AGILITY: stat = ally_agility_ff;
            default:                 stat = ally_wisdom_ff;
         endcase
      end else if (top_ff == sbi_pkg::UNIT_ENEMY) begin
         unique case (op_ff)
            sbi_pkg::OP_GET_HEALTH:  stat = enemy_health_ff;
            sbi_pkg::OP_GET_AGILITY: stat = enemy_agility_ff;
            default:                 stat = enemy_wisdom_ff;
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      sp_in            = sp_ff;
      top_in           = top_ff;
      op_in            = op_ff;
      lit_in           = lit_ff;
      ally_health_in   = ally_health_ff;
      enemy_health_in  = enemy_health_ff;
      ally_agility_in  = ally_agility_ff;
      ally_wisdom_in   = ally_wisdom_ff;
      enemy_agility_in = enemy_agility_ff;
      enemy_wisdom_in  = enemy_wisdom_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_top_in       = rsp_top_ff;
      rsp_depth_in     = rsp_depth_ff;
      rsp_status_in    = rsp_status_ff;
      resp_fire        = 1'b0;
      resp_sp          = sp_ff;
      resp_top         = top_ff;
      resp_status      = sbi_pkg::STAT_OK;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = AW'(sp_m2);
      ram_wr_data      = sum;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = AW'(sp_m2);
      div_start        = 1'b0;

      if (csr_wr_en) begin
         unique case (sbi_pkg::csr_index_type'(csr_index))
            sbi_pkg::CSR_ALLY_AGILITY:  ally_agility_in  = csr_wr_data;
            sbi_pkg::CSR_ALLY_WISDOM:   ally_wisdom_in   = csr_wr_data;
            sbi_pkg::CSR_ENEMY_AGILITY: enemy_agility_in = csr_wr_data;
            sbi_pkg::CSR_ENEMY_WISDOM:  enemy_wisdom_in  = csr_wr_data;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = sbi_pkg::op_type'(req_tdata[sbi_pkg::OP_W-1:0]);
               lit_in    = req_tdata[sbi_pkg::REQ_LIT_LSB +: W];
               // second operand fetch; unused by ops that do not need it
               ram_rd_en = 1'b1;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            if (slot_free) begin
               resp_fire = 1'b1;
               state_in  = S_IDLE;
               unique case (op_ff)
                  sbi_pkg::OP_NONE: begin
                  end
                  sbi_pkg::OP_LITERAL: begin
                     if (sp_ff == SW'(sbi_pkg::STACK_DEPTH)) begin
                        resp_status = sbi_pkg::STAT_OVER;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(sp_ff);
                        ram_wr_data = lit_ff;
                        sp_in       = sp_ff + SW'(1);
                        top_in      = lit_ff;
                        resp_sp     = sp_ff + SW'(1);
                        resp_top    = lit_ff;
                     end
                  end
                  sbi_pkg::OP_ADD, sbi_pkg::OP_DIVIDE, sbi_pkg::OP_SET_HEALTH: begin
                     if (sp_ff < SW'(2)) begin
                        resp_status = sbi_pkg::STAT_UNDER;
                     end else if (op_ff == sbi_pkg::OP_ADD) begin
                        ram_wr_en = 1'b1;
                        sp_in     = sp_m1;
                        top_in    = sum;
                        resp_sp   = sp_m1;
                        resp_top  = sum;
                     end else if (op_ff == sbi_pkg::OP_DIVIDE) begin
                        if (opnd_b == '0) begin
                           resp_status = sbi_pkg::STAT_DIVZ;
                        end else begin
                           div_start = 1'b1;
                           resp_fire = 1'b0;
                           state_in  = S_DIVIDE;
                        end
                     end else begin
                        // set health: writes to unknown units are dropped
                        if (opnd_a == sbi_pkg::UNIT_ALLY) begin
                           ally_health_in = opnd_b;
                        end else if (opnd_a == sbi_pkg::UNIT_ENEMY) begin
                           enemy_health_in = opnd_b;
                        end
                        sp_in   = sp_m2;
                        resp_sp = sp_m2;
                        if (sp_m2 != '0) begin
                           // new top lives in RAM only: fetch it
                           ram_rd_en   = 1'b1;
                           ram_rd_addr = AW'(sp_m3);
                           resp_fire   = 1'b0;
                           state_in    = S_REFILL;
                        end
                     end
                  end
                  sbi_pkg::OP_GET_HEALTH, sbi_pkg::OP_GET_AGILITY,
                  sbi_pkg::OP_GET_WISDOM: begin
                     if (sp_ff == '0) begin
                        resp_status = sbi_pkg::STAT_UNDER;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(sp_m1);
                        ram_wr_data = stat;
                        top_in      = stat;
                        resp_top    = stat;
                     end
                  end
               endcase
            end
         end

         S_DIVIDE: begin
            if (!div_busy && slot_free) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = div_quotient;
               sp_in       = sp_m1;
               top_in      = div_quotient;
               resp_fire   = 1'b1;
               resp_sp     = sp_m1;
               resp_top    = div_quotient;
               state_in    = S_IDLE;
            end
         end

         S_REFILL: begin
            if (slot_free) begin
               top_in    = ram_rd_data;
               resp_fire = 1'b1;
               resp_top  = ram_rd_data;
               state_in  = S_IDLE;
            end
         end
      endcase

      if (resp_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_top_in    = (resp_sp != '0) ? resp_top : '0;
         rsp_depth_in  = sbi_pkg::DEPTH_W'(resp_sp);
         rsp_status_in = resp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         sp_ff            <= '0;
         rsp_valid_ff     <= 1'b0;
         ally_health_ff   <= sbi_pkg::ALLY_HEALTH_RST;
         enemy_health_ff  <= sbi_pkg::ENEMY_HEALTH_RST;
         ally_agility_ff  <= sbi_pkg::ALLY_AGILITY_RST;
         ally_wisdom_ff   <= sbi_pkg::ALLY_WISDOM_RST;
         enemy_agility_ff <= sbi_pkg::ENEMY_AGILITY_RST;
         enemy_wisdom_ff  <= sbi_pkg::ENEMY_WISDOM_RST;
      end else begin
         state_ff         <= state_in;
         sp_ff            <= sp_in;
         rsp_valid_ff     <= rsp_valid_in;
         ally_health_ff   <= ally_health_in;
         enemy_health_ff  <= enemy_health_in;
         ally_agility_ff  <= ally_agility_in;
         ally_wisdom_ff   <= ally_wisdom_in;
         enemy_agility_ff <= enemy_agility_in;
         enemy_wisdom_ff  <= enemy_wisdom_in;
      end
      top_ff        <= top_in;
      op_ff         <= op_in;
      lit_ff        <= lit_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sbi_pkg::RSP_TDATA_W'({rsp_status_ff, rsp_depth_ff, rsp_top_ff});

endmodule

// ----- rtl/sbi_stack_ram.sv -----
// sbi_stack_ram: stack word storage, one write and one read port, registered read.
// Depends on sbi_pkg for depth and width.

module sbi_stack_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [sbi_pkg::ADDR_W-1:0]       wr_addr,
   input  logic [sbi_pkg::DATA_W-1:0]       wr_data,
   input  logic                             rd_en,
   input  logic [sbi_pkg::ADDR_W-1:0]       rd_addr,
   output logic [sbi_pkg::DATA_W-1:0]       rd_data
);

   logic [sbi_pkg::DATA_W-1:0] mem [sbi_pkg::STACK_DEPTH];
   logic [sbi_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sbi_divider.sv -----
// sbi_divider: signed 32-bit divide, truncating toward zero, one quotient bit per cycle.
// Depends on sbi_pkg for widths. Divisor must be nonzero at start.

module sbi_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sbi_pkg::DATA_W-1:0] dividend,
   input  logic [sbi_pkg::DATA_W-1:0] divisor,
   output logic                       busy,
   output logic [sbi_pkg::DATA_W-1:0] quotient
);

   localparam int W = sbi_pkg::DATA_W;

   logic               busy_ff, busy_in;
   logic [sbi_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]       rem_ff, rem_in;
   logic [W-1:0]       quo_ff, quo_in;
   logic [W-1:0]       dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic [W:0]         shifted;
   logic [W:0]         diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = dividend[W-1] ^ divisor[W-1];
         quo_in  = dividend[W-1] ? (W'(0) - dividend) : dividend;
         dvs_in  = divisor[W-1] ? (W'(0) - divisor) : divisor;
      end else if (busy_ff) begin
         // restoring step: quotient bit set when the trial subtract stays non-negative
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + sbi_pkg::DIV_CNT_W'(1);
         if (cnt_ff == sbi_pkg::DIV_CNT_W'(W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? (W'(0) - quo_ff) : quo_ff;

endmodule

// ----- rtl/sbi_checker.sv -----
// sbi_checker: port-level assertions for stack_bytecode_interpreter, plus its bind.
// Depends on sbi_pkg for payload layout and codes.

module sbi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sbi_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic [sbi_pkg::DATA_W-1:0]   rsp_top;
   logic [sbi_pkg::DEPTH_W-1:0]  rsp_depth;
   logic [sbi_pkg::STATUS_W-1:0] rsp_status;

   assign rsp_top    = rsp_tdata[sbi_pkg::DATA_W-1:0];
   assign rsp_depth  = rsp_tdata[sbi_pkg::RSP_DEPTH_LSB +: sbi_pkg::DEPTH_W];
   assign rsp_status = rsp_tdata[sbi_pkg::RSP_STATUS_LSB +: sbi_pkg::STATUS_W];

   // no result pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one instruction in flight: ready drops after each transaction
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second instruction accepted while one in flight");

   // empty stack reports zero on top
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_depth == '0 |-> rsp_top == '0)
      else $error("nonzero top with empty stack");

   // overflow only on a full stack
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == sbi_pkg::STAT_OVER
      |-> rsp_depth == sbi_pkg::DEPTH_W'(sbi_pkg::STACK_DEPTH))
      else $error("overflow reported below full depth");

endmodule

bind stack_bytecode_interpreter sbi_checker u_sbi_checker (.*);
